>>> src/kmp_pkg.sv
// shared types and constants of the kmp string matcher
package kmp_pkg;

    localparam int PATTERN_DEPTH = 64;
    localparam int ADDR_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // input func codes
    localparam logic [1:0] FN_FIRST = 2'd0;
    localparam logic [1:0] FN_NEXT = 2'd1;
    localparam logic [1:0] FN_TEXT = 2'd2;
    localparam logic [1:0] FN_END = 2'd3;

    // result kinds
    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        OP_RESTART,
        OP_APPEND,
        OP_TEXT,
        OP_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] position;
        logic [31:0] total;
        logic        overflow;
    } result_t;

endpackage

>>> src/kmp_ram.sv
// generic single-write, single-read ram with registered read data
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/kmp_front.sv
// input side: decodes each item into a command and queues it for the back end
module kmp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic [1:0]    s_tuser,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output kmp_pkg::cmd_t cmd
);

    import kmp_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;
    cmd_t              in_cmd;

    always_comb
    begin
        in_cmd.data = s_tdata;
        case (s_tuser)
            FN_FIRST: in_cmd.op = OP_RESTART;
            FN_NEXT:  in_cmd.op = OP_APPEND;
            FN_TEXT:  in_cmd.op = OP_TEXT;
            default:  in_cmd.op = OP_END;
        endcase
    end

    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd = q_reg[rd_ptr_reg];
    assign push = s_tvalid && s_tready;
    assign pop = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> src/kmp_back.sv
// back end: pattern store, failure-link walks, match counting and result register
module kmp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  kmp_pkg::cmd_t    cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output kmp_pkg::result_t res
);

    import kmp_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [7:0]        c_reg, c_next;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]  last_fail_reg, last_fail_next;
    logic [31:0]       pos_reg, pos_next;
    logic [31:0]       cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;

    logic              out_free;
    logic [LEN_W-1:0]  k_issue;
    logic [LEN_W-1:0]  k_fin;
    logic              hit;
    logic              pat_we, fail_we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        pat_wdata;
    logic [LEN_W-1:0]  fail_wdata;
    logic [7:0]        pat_rdata;
    logic [LEN_W-1:0]  fail_rdata;
    logic [LEN_W-1:0]  fail_raddr_full;

    assign out_free = !res_valid_reg || res_ready;
    assign hit = (pat_rdata == c_reg);
    assign fail_raddr_full = k_issue - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        c_next = c_reg;
        k_next = k_reg;
        len_next = len_reg;
        idx_next = idx_reg;
        last_fail_next = last_fail_reg;
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next = res_reg;
        cmd_ready = 1'b0;
        k_issue = k_reg;
        k_fin = '0;
        pat_we = 1'b0;
        fail_we = 1'b0;
        waddr = len_reg[ADDR_W-1:0];
        pat_wdata = c_reg;
        fail_wdata = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_ready = 1'b1;
                    op_next = cmd.op;
                    c_next = cmd.data;
                    case (cmd.op)
                        OP_RESTART, OP_APPEND:
                        begin
                            if (cmd.op == OP_RESTART || len_reg == '0)
                            begin
                                // pattern starts over with this byte alone
                                if (cmd.op == OP_RESTART)
                                begin
                                    ovf_next = 1'b0;
                                    idx_next = '0;
                                end
                                pat_we = 1'b1;
                                fail_we = 1'b1;
                                waddr = '0;
                                pat_wdata = cmd.data;
                                fail_wdata = '0;
                                last_fail_next = '0;
                                len_next = LEN_W'(1);
                            end
                            else if (len_reg >= LEN_W'(PATTERN_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                k_issue = last_fail_reg;
                                k_next = last_fail_reg;
                                state_next = ST_WALK;
                            end
                        end
                        OP_TEXT:
                        begin
                            if (len_reg == '0)
                            begin
                                pos_next = pos_reg + 32'd1;
                            end
                            else
                            begin
                                k_issue = (idx_reg >= len_reg) ? '0 : idx_reg;
                                k_next = k_issue;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            res_next.kind = KIND_SUMMARY;
                            res_next.position = '0;
                            res_next.total = cnt_reg;
                            res_next.overflow = ovf_reg;
                            pos_next = '0;
                            idx_next = '0;
                            cnt_next = '0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (!hit && k_reg != '0)
                begin
                    // follow one failure link, read data feeds the next address
                    k_issue = fail_rdata;
                    k_next = fail_rdata;
                end
                else
                begin
                    k_fin = hit ? k_reg + 1'b1 : '0;
                    state_next = ST_IDLE;
                    if (op_reg == OP_TEXT)
                    begin
                        pos_next = pos_reg + 32'd1;
                        if (k_fin == len_reg)
                        begin
                            res_valid_next = 1'b1;
                            res_next.kind = KIND_MATCH;
                            res_next.position = pos_reg - 32'(len_reg) + 32'd1;
                            res_next.total = '0;
                            res_next.overflow = 1'b0;
                            if (cnt_reg != '1)
                            begin
                                cnt_next = cnt_reg + 32'd1;
                            end
                            idx_next = last_fail_reg;
                        end
                        else
                        begin
                            idx_next = k_fin;
                        end
                    end
                    else
                    begin
                        pat_we = 1'b1;
                        fail_we = 1'b1;
                        waddr = len_reg[ADDR_W-1:0];
                        pat_wdata = c_reg;
                        fail_wdata = k_fin;
                        last_fail_next = k_fin;
                        len_next = len_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_END;
            k_reg <= '0;
            len_reg <= '0;
            idx_reg <= '0;
            last_fail_reg <= '0;
            pos_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            k_reg <= k_next;
            len_reg <= len_next;
            idx_reg <= idx_next;
            last_fail_reg <= last_fail_next;
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        res_reg <= res_next;
    end

    kmp_ram #(
        .WIDTH(8),
        .DEPTH(PATTERN_DEPTH)
    ) u_pattern_ram (
        .clk  (clk),
        .we   (pat_we),
        .waddr(waddr),
        .wdata(pat_wdata),
        .raddr(k_issue[ADDR_W-1:0]),
        .rdata(pat_rdata)
    );

    kmp_ram #(
        .WIDTH(LEN_W),
        .DEPTH(PATTERN_DEPTH)
    ) u_failure_ram (
        .clk  (clk),
        .we   (fail_we),
        .waddr(waddr),
        .wdata(fail_wdata),
        .raddr(fail_raddr_full[ADDR_W-1:0]),
        .rdata(fail_rdata)
    );

    assign res_valid = res_valid_reg;
    assign res = res_reg;

`ifndef SYNTH
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(PATTERN_DEPTH))
        else $error("pattern length beyond store depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg < len_reg) || (idx_reg == '0))
        else $error("match index not below pattern length");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (k_reg < len_reg))
        else $error("failure walk left the written part of the store");

    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> (!res_valid_reg || res_ready))
        else $error("command taken while result register is blocked");
`endif

endmodule

>>> src/kmp_string_matcher_core.sv
// top level of the kmp string matcher: input queue, matching back end, port packing
//
// Items enter through a two-entry queue, so the input keeps accepting while the
// back end works or a result waits on the output register. A first-pattern byte,
// an end-of-text item, a dropped pattern byte or a text byte with an empty
// pattern is finished in the back end's idle state. Any other pattern or text
// byte also passes through its walk state, which follows failure links until the
// byte matches or the link index is zero: the back end walks the failure table
// one link per cycle through the registered read of its ram. A match or a summary
// is held in the output register until taken, and the back end starts no new
// item while that register is full and not being drained.
module kmp_string_matcher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // match_position[31:0], total_matches[63:32],
                                   // pattern_overflow[64], zero[71:65]
    output logic        m_tuser    // result_kind[0]
);

    import kmp_pkg::*;

    logic    cmd_valid;
    logic    cmd_ready;
    cmd_t    cmd;
    result_t res;

    kmp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd)
    );

    kmp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .res_valid(m_tvalid),
        .res_ready(m_tready),
        .res      (res)
    );

    assign m_tdata = {7'b0, res.overflow, res.total, res.position};
    assign m_tuser = res.kind;

endmodule

>>> verif/kmp_string_matcher_core_test.sv
// self-checking testbench of the kmp string matcher core
module kmp_string_matcher_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kmp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte[7:0]
    logic [1:0]  s_tuser;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // match_position[31:0], total_matches[63:32],
                            // pattern_overflow[64], zero[71:65]
    logic        m_tuser;   // result_kind[0]

    kmp_string_matcher_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // matcher state as the block should hold it
    logic [7:0]  pat_mem [PATTERN_DEPTH];
    int unsigned border_len [PATTERN_DEPTH];
    int unsigned pat_len;
    int unsigned matched;
    logic [31:0] text_pos;
    logic [31:0] match_cnt;
    logic        pat_dropped;

    result_t     pending_reports [$];
    int          error_count;
    int          items_sent;
    bit          no_idle;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void store_pattern_byte(input logic [7:0] c);
        int unsigned i;
        int unsigned k;
        i = pat_len;
        if (i >= PATTERN_DEPTH)
        begin
            pat_dropped = 1'b1;
            return;
        end
        pat_mem[i] = c;
        if (i == 0)
        begin
            border_len[0] = 0;
        end
        else
        begin
            k = border_len[i - 1];
            while (k > 0 && pat_mem[k] != c)
                k = border_len[k - 1];
            if (pat_mem[k] == c)
                k++;
            border_len[i] = k;
        end
        pat_len = i + 1;
    endfunction

    // update the matcher state for one accepted item, queue the report it causes
    function automatic void advance_matcher(input op_t op, input logic [7:0] c);
        int unsigned k;
        result_t     r;
        case (op)
            OP_RESTART:
            begin
                pat_len     = 0;
                matched     = 0;
                pat_dropped = 1'b0;
                store_pattern_byte(c);
            end
            OP_APPEND: store_pattern_byte(c);
            OP_TEXT:
            begin
                if (pat_len > 0)
                begin
                    if (matched >= pat_len)
                        matched = 0;
                    k = matched;
                    while (k > 0 && k < pat_len && pat_mem[k] != c)
                        k = border_len[k - 1];
                    if (k < pat_len && pat_mem[k] == c)
                        k++;
                    matched = k;
                    if (matched == pat_len)
                    begin
                        r.kind     = KIND_MATCH;
                        r.position = text_pos - pat_len + 1;
                        r.total    = '0;
                        r.overflow = 1'b0;
                        pending_reports.push_back(r);
                        if (match_cnt != 32'hFFFF_FFFF)
                            match_cnt++;
                        // keep going from the border so overlaps are found
                        matched = border_len[pat_len - 1];
                    end
                end
                text_pos++;
            end
            default:
            begin
                r.kind     = KIND_SUMMARY;
                r.position = '0;
                r.total    = match_cnt;
                r.overflow = pat_dropped;
                pending_reports.push_back(r);
                text_pos  = '0;
                matched   = 0;
                match_cnt = '0;
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual kind %0d data %h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("result_kind", want.kind, m_tuser);
                compare_field("match_position", want.position, m_tdata[31:0]);
                compare_field("total_matches", want.total, m_tdata[63:32]);
                compare_field("pattern_overflow", want.overflow, m_tdata[64]);
            end
        end
    end

    // result side: random stall before each item is taken
    initial
    begin : drain_results
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic send_item(input op_t op, input logic [7:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        advance_matcher(op, value);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    // load a pattern from a small alphabet, then scan a text that holds copies of it
    task automatic run_text_segment(input int plen, input int draws, input int nalpha,
                                    input bit extend);
        logic [7:0] alpha [$];
        logic [7:0] pat [$];
        logic [7:0] c;
        int         copy_at;
        repeat (nalpha) alpha.push_back(8'($urandom));
        for (int i = 0; i < plen; i++)
        begin
            c = alpha[$urandom_range(0, nalpha - 1)];
            send_item(i == 0 ? OP_RESTART : OP_APPEND, c);
            if (pat.size() < PATTERN_DEPTH)
                pat.push_back(c);
        end
        copy_at = $urandom_range(0, draws - 1);
        for (int j = 0; j < draws; j++)
        begin
            // pattern grows in the middle of the text
            if (extend && j == draws / 2)
            begin
                c = alpha[$urandom_range(0, nalpha - 1)];
                send_item(OP_APPEND, c);
                if (pat.size() < PATTERN_DEPTH)
                    pat.push_back(c);
            end
            if (j == copy_at || $urandom_range(0, 7) == 0)
                foreach (pat[k]) send_item(OP_TEXT, pat[k]);
            else
                send_item(OP_TEXT, alpha[$urandom_range(0, nalpha - 1)]);
        end
        send_item(OP_END, 8'($urandom));
    endtask

    task automatic test_empty_pattern();
        send_item(OP_TEXT, 8'h00);     // no pattern yet, only the position moves
        send_item(OP_APPEND, 8'hFF);   // append on empty pattern starts it
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_TEXT, 8'h00);
        send_item(OP_END, 8'hA5);
    endtask

    task automatic test_overlap_and_extend();
        send_item(OP_RESTART, 8'h61);
        send_item(OP_APPEND, 8'h61);
        repeat (4) send_item(OP_TEXT, 8'h61);
        send_item(OP_APPEND, 8'h62);   // partial match must survive the extension
        send_item(OP_TEXT, 8'h61);
        send_item(OP_TEXT, 8'h62);
        send_item(OP_END, 8'h00);
    endtask

    task automatic test_byte_extremes();
        send_item(OP_RESTART, 8'h00);
        send_item(OP_TEXT, 8'h00);
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_RESTART, 8'hFF);  // restart keeps position and count
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_END, 8'hFF);
    endtask

    task automatic test_long_patterns();
        run_text_segment(PATTERN_DEPTH, 4, 2, 1'b0);
        run_text_segment(PATTERN_DEPTH + 3, 4, 2, 1'b1);
        run_text_segment(40, 5, 1, 1'b0);
        wait_for_drain();
    endtask

    task automatic test_random_texts();
        int goal;
        int segs;
        goal = items_sent + 100;
        segs = 0;
        while (items_sent < goal)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 5))
                       send_item(op_t'($urandom_range(0, 3)), 8'($urandom));
                1: run_text_segment($urandom_range(8, 30), $urandom_range(2, 5),
                                    $urandom_range(1, 2), $urandom_range(0, 1));
                default: run_text_segment($urandom_range(1, 6), $urandom_range(3, 16),
                                          $urandom_range(1, 3), $urandom_range(0, 9) == 0);
            endcase
            segs++;
            if (segs == 10)
                wait_for_drain();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        error_count = 0;
        items_sent  = 0;
        no_idle     = 1'b0;
        pat_len     = 0;
        matched     = 0;
        text_pos    = '0;
        match_cnt   = '0;
        pat_dropped = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pattern();
        test_overlap_and_extend();
        test_byte_extremes();
        test_long_patterns();
        test_random_texts();

        wait_for_drain();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> kmp_string_matcher_core.f
src/kmp_pkg.sv
src/kmp_ram.sv
src/kmp_front.sv
src/kmp_back.sv
src/kmp_string_matcher_core.sv
verif/kmp_string_matcher_core_test.sv
